// ----- rtl/ecpa_pkg.sv -----
// Shared constants and field helpers for the secp256k1 mixed point adder.
// Used by ecpa_mul and ec_mixed_point_add_unit; no dependencies.
package ecpa_pkg;

  localparam logic [255:0] P_MOD =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;

  // 2^256 mod p
  localparam logic [255:0] FOLD_K = 256'h1_000003D1;

  // Multiplier latency in cycles, operand in to product out
  localparam int MUL_LAT = 12;

  // Write port register indexes
  localparam logic [2:0] REG_BX_WORD0 = 3'd0;
  localparam logic [2:0] REG_BX_WORD1 = 3'd1;
  localparam logic [2:0] REG_BX_WORD2 = 3'd2;
  localparam logic [2:0] REG_BX_WORD3 = 3'd3;
  localparam logic [2:0] REG_BY_WORD0 = 3'd4;
  localparam logic [2:0] REG_BY_WORD1 = 3'd5;
  localparam logic [2:0] REG_BY_WORD2 = 3'd6;
  localparam logic [2:0] REG_BY_WORD3 = 3'd7;

  // Reduce a value known below 2p
  function automatic logic [255:0] fe_norm(input logic [256:0] v);
    logic [257:0] d;
    begin
      d = {1'b0, v} - {2'b00, P_MOD};
      fe_norm = d[257] ? v[255:0] : d[255:0];
    end
  endfunction

  // (a + b) mod p for reduced a, b
  function automatic logic [255:0] fe_add(input logic [255:0] a, input logic [255:0] b);
    logic [257:0] s;
    logic [257:0] d;
    begin
      s = {2'b00, a} + {2'b00, b};
      d = {2'b00, a} + {2'b00, b} - {2'b00, P_MOD};
      fe_add = d[257] ? s[255:0] : d[255:0];
    end
  endfunction

  // (a - b) mod p for reduced a, b
  function automatic logic [255:0] fe_sub(input logic [255:0] a, input logic [255:0] b);
    logic [256:0] d;
    logic [255:0] w;
    begin
      d = {1'b0, a} - {1'b0, b};
      w = a + P_MOD - b;
      fe_sub = d[256] ? w : d[255:0];
    end
  endfunction

endpackage

// ----- rtl/ecpa_mul.sv -----
// Pipelined 256x256 multiplier modulo p, MUL_LAT register stages.
// Depends on ecpa_pkg for the prime and fold constant.
module ecpa_mul
  import ecpa_pkg::*;
(
  input  logic         clk,
  input  logic [255:0] a,
  input  logic [255:0] b,
  output logic [255:0] r
);

  logic [255:0] a_q, b_q;
  logic [63:0]  pp [8][8];
  logic [287:0] row [8];
  logic [319:0] pair [4];
  logic [383:0] quad [2];
  logic [511:0] prod;
  logic [41:0]  lane [8];
  logic [255:0] lo_a, lo_b, hi_b;
  logic [287:0] hm;
  logic [288:0] v;
  logic [256:0] w;
  logic [255:0] x;
  logic [42:0]  h2m;
  logic [32:0]  h2;

  // Capture operands
  always_ff @(posedge clk) begin
    a_q <= a;
    b_q <= b;
  end

  // 32x32 partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        pp[i][j] <= 64'(a_q[32*i +: 32]) * 64'(b_q[32*j +: 32]);
      end
    end
  end

  // One row per word of a: even products and odd products each pack without overlap, then the two are added
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      row[i] <= {32'd0, pp[i][6], pp[i][4], pp[i][2], pp[i][0]}
              + {pp[i][7], pp[i][5], pp[i][3], pp[i][1], 32'd0};
    end
  end

  // Adder tree over rows
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pair[k] <= {32'd0, row[2*k]} + {row[2*k+1], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      quad[k] <= {64'd0, pair[2*k]} + {pair[2*k+1], 64'd0};
    end
  end

  always_ff @(posedge clk) begin
    prod <= {128'd0, quad[0]} + {quad[1], 128'd0};
  end

  // First fold: high half times 977 in narrow lanes
  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      lane[k] <= 42'(prod[256 + 32*k +: 32]) * 42'd977;
    end
    lo_a <= prod[255:0];
    hi_b <= prod[511:256];
  end

  always_ff @(posedge clk) begin
    hm <= {32'd0, 22'd0, lane[6], 22'd0, lane[4], 22'd0, lane[2], 22'd0, lane[0]}
        + {22'd0, lane[7], 22'd0, lane[5], 22'd0, lane[3], 22'd0, lane[1], 32'd0};
    lo_b <= lo_a;
  end

  // Add low half, high half shifted by 32 and high half times 977
  logic [255:0] hi_c;
  always_ff @(posedge clk) begin
    hi_c <= hi_b;
  end

  always_ff @(posedge clk) begin
    v <= {33'd0, lo_b} + {1'b0, hi_c, 32'd0} + {23'd0, hm[265:0]};
  end

  // Second fold of the 33-bit overflow
  assign h2  = v[288:256];
  assign h2m = 43'(h2) * 43'd977;

  always_ff @(posedge clk) begin
    w <= {1'b0, v[255:0]} + {192'd0, h2, 32'd0} + {214'd0, h2m};
  end

  // Last fold of a single carry bit
  always_ff @(posedge clk) begin
    x <= w[255:0] + (w[256] ? FOLD_K : 256'd0);
  end

  // Final conditional subtract
  always_ff @(posedge clk) begin
    r <= fe_norm({1'b0, x});
  end

endmodule

// ----- rtl/ec_mixed_point_add_unit.sv -----
// Top level of the secp256k1 mixed point adder: R = A (Jacobian) + B (affine).
// Depends on ecpa_pkg and ecpa_mul.
//
// The unit takes one point on every clock cycle (busy is always low) and puts
// each result on rx/ry/rz for one cycle with done high, in input order. The
// result path chains modular multipliers with input, add and subtract stages.
// Results cannot be held off, so the receiver must take done at any cycle. B
// is loaded through the write port (index 0..3 x words, 4..7 y words); the user
// must load it only while no point is in flight, which the unit does not enforce.
// A at infinity and equal x coordinates are not detected.
module ec_mixed_point_add_unit
  import ecpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] ax_word0,
  input  logic [63:0] ax_word1,
  input  logic [63:0] ax_word2,
  input  logic [63:0] ax_word3,
  input  logic [63:0] ay_word0,
  input  logic [63:0] ay_word1,
  input  logic [63:0] ay_word2,
  input  logic [63:0] ay_word3,
  input  logic [63:0] az_word0,
  input  logic [63:0] az_word1,
  input  logic [63:0] az_word2,
  input  logic [63:0] az_word3,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  output logic        done,
  output logic [63:0] rx_word0,
  output logic [63:0] rx_word1,
  output logic [63:0] rx_word2,
  output logic [63:0] rx_word3,
  output logic [63:0] ry_word0,
  output logic [63:0] ry_word1,
  output logic [63:0] ry_word2,
  output logic [63:0] ry_word3,
  output logic [63:0] rz_word0,
  output logic [63:0] rz_word1,
  output logic [63:0] rz_word2,
  output logic [63:0] rz_word3
);

  localparam int L = MUL_LAT;

  localparam int AZ_D = 3*L;
  localparam int AX_D = 4*L;
  localparam int AY_D = 5*L + 4;
  localparam int H_D  = 2*L - 1;
  localparam int I_D  = 2*L + 3;
  localparam int I2_D = L + 2;
  localparam int H3_D = 4;
  localparam int T_D  = 3;
  localparam int RX_D = L + 2;
  localparam int RZ_D = 2*L + 5;
  localparam int V_D  = 6*L + 5;

  logic [255:0] bx, by, bxn, byn;
  logic [255:0] ax0, ay0, az0, ax1, ay1, az1;
  logic         v0, v1;
  logic [255:0] z2, u2, t1, s2, i_c, h, i_r, i2, h2, rz, h3, t;
  logic [255:0] t2, hsum, rx, dd, m1, m2, ry;
  logic [255:0] az_h [AZ_D];
  logic [255:0] ax_h [AX_D];
  logic [255:0] ay_h [AY_D];
  logic [255:0] h_h  [H_D];
  logic [255:0] i_h  [I_D];
  logic [255:0] i2_h [I2_D];
  logic [255:0] h3_h [H3_D];
  logic [255:0] t_h  [T_D];
  logic [255:0] rx_h [RX_D];
  logic [255:0] rz_h [RZ_D];
  logic         v_h  [V_D];

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bx <= '0;
      by <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_BX_WORD0: bx[63:0]    <= wr_data;
        REG_BX_WORD1: bx[127:64]  <= wr_data;
        REG_BX_WORD2: bx[191:128] <= wr_data;
        REG_BX_WORD3: bx[255:192] <= wr_data;
        REG_BY_WORD0: by[63:0]    <= wr_data;
        REG_BY_WORD1: by[127:64]  <= wr_data;
        REG_BY_WORD2: by[191:128] <= wr_data;
        REG_BY_WORD3: by[255:192] <= wr_data;
        default: ;
      endcase
    end
  end

  assign bxn = fe_norm({1'b0, bx});
  assign byn = fe_norm({1'b0, by});

  // Capture the point, then reduce each coordinate
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    ax0 <= {ax_word3, ax_word2, ax_word1, ax_word0};
    ay0 <= {ay_word3, ay_word2, ay_word1, ay_word0};
    az0 <= {az_word3, az_word2, az_word1, az_word0};
    ax1 <= fe_norm({1'b0, ax0});
    ay1 <= fe_norm({1'b0, ay0});
    az1 <= fe_norm({1'b0, az0});
  end

  // Operand delay lines
  always_ff @(posedge clk) begin
    az_h[0] <= az1;
    for (int k = 1; k < AZ_D; k++) az_h[k] <= az_h[k-1];
    ax_h[0] <= ax1;
    for (int k = 1; k < AX_D; k++) ax_h[k] <= ax_h[k-1];
    ay_h[0] <= ay1;
    for (int k = 1; k < AY_D; k++) ay_h[k] <= ay_h[k-1];
    h_h[0] <= h;
    for (int k = 1; k < H_D; k++) h_h[k] <= h_h[k-1];
    i_h[0] <= i_r;
    for (int k = 1; k < I_D; k++) i_h[k] <= i_h[k-1];
    i2_h[0] <= i2;
    for (int k = 1; k < I2_D; k++) i2_h[k] <= i2_h[k-1];
    h3_h[0] <= h3;
    for (int k = 1; k < H3_D; k++) h3_h[k] <= h3_h[k-1];
    t_h[0] <= t;
    for (int k = 1; k < T_D; k++) t_h[k] <= t_h[k-1];
    rx_h[0] <= rx;
    for (int k = 1; k < RX_D; k++) rx_h[k] <= rx_h[k-1];
    rz_h[0] <= rz;
    for (int k = 1; k < RZ_D; k++) rz_h[k] <= rz_h[k-1];
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < V_D; k++) v_h[k] <= 1'b0;
    end else begin
      v_h[0] <= v1;
      for (int k = 1; k < V_D; k++) v_h[k] <= v_h[k-1];
    end
  end

  // Z^2, then Bx*Z^2 and By*Z^2, then By*Z^3
  ecpa_mul u_z2 (.clk(clk), .a(az1), .b(az1), .r(z2));
  ecpa_mul u_u2 (.clk(clk), .a(bxn), .b(z2),  .r(u2));
  ecpa_mul u_t1 (.clk(clk), .a(byn), .b(z2),  .r(t1));
  ecpa_mul u_s2 (.clk(clk), .a(t1),  .b(az_h[2*L-1]), .r(s2));

  // h and i
  always_ff @(posedge clk) begin
    h   <= fe_sub(u2, ax_h[2*L-1]);
    i_r <= i_c;
  end

  assign i_c = fe_sub(s2, ay_h[3*L-1]);

  // i^2, h^2, Rz
  ecpa_mul u_i2 (.clk(clk), .a(i_c), .b(i_c), .r(i2));
  ecpa_mul u_h2 (.clk(clk), .a(h_h[L-2]), .b(h_h[L-2]), .r(h2));
  ecpa_mul u_rz (.clk(clk), .a(az_h[3*L-1]), .b(h_h[L-2]), .r(rz));

  // h^3 and X*h^2
  ecpa_mul u_h3 (.clk(clk), .a(h_h[2*L-2]), .b(h2), .r(h3));
  ecpa_mul u_t  (.clk(clk), .a(ax_h[4*L-1]), .b(h2), .r(t));

  // Rx = i^2 - 2t - h^3, then t - Rx
  always_ff @(posedge clk) begin
    t2   <= fe_add(t, t);
    hsum <= fe_add(t2, h3_h[0]);
    rx   <= fe_sub(i2_h[L+1], hsum);
    dd   <= fe_sub(t_h[2], rx);
  end

  // Ry = i*(t - Rx) - Y*h^3
  ecpa_mul u_m1 (.clk(clk), .a(dd), .b(i_h[2*L+2]), .r(m1));
  ecpa_mul u_m2 (.clk(clk), .a(h3_h[3]), .b(ay_h[5*L+3]), .r(m2));

  always_ff @(posedge clk) begin
    ry <= fe_sub(m1, m2);
  end

  // Result ports
  assign done     = v_h[V_D-1];
  assign rx_word0 = rx_h[RX_D-1][63:0];
  assign rx_word1 = rx_h[RX_D-1][127:64];
  assign rx_word2 = rx_h[RX_D-1][191:128];
  assign rx_word3 = rx_h[RX_D-1][255:192];
  assign ry_word0 = ry[63:0];
  assign ry_word1 = ry[127:64];
  assign ry_word2 = ry[191:128];
  assign ry_word3 = ry[255:192];
  assign rz_word0 = rz_h[RZ_D-1][63:0];
  assign rz_word1 = rz_h[RZ_D-1][127:64];
  assign rz_word2 = rz_h[RZ_D-1][191:128];
  assign rz_word3 = rz_h[RZ_D-1][255:192];

endmodule
